FILE: hw/rtl/ssfs_pkg.sv
`default_nettype none
package ssfs_pkg;

  // field and register widths
  localparam int CMD_W      = 3;
  localparam int JIT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int VAL_W      = 16;
  localparam int WAIT_W     = 17;
  localparam int REP_W      = 17;

  // shared divider geometry
  localparam int DVD_W     = 33;
  localparam int DVS_W     = 17;
  localparam int DIV_CNT_W = 6;

  // extra pixels between sheet rows
  localparam logic [7:0] ROW_GAP = 8'd0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE    = 3'd7;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DIVF,
    S_MULX,
    S_MODS,
    S_MODW,
    S_YS,
    S_YW,
    S_MULY,
    S_FIN
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input transaction
    logic exec;     // apply the command to the sequencer state
    logic div_fpr;  // start frames-per-row division
    logic mul_x;    // pitch times frame index
    logic div_mod;  // start source x modulo
    logic div_y;    // start row number division
    logic mul_y;    // row number times row height
    logic fin;      // load output register, step the index
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_start;
    logic draw_go;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ssfs_if.sv
`default_nettype none
interface ssfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssfs_pkg::CMD_W-1:0]  cmd;
  logic [ssfs_pkg::JIT_W-1:0]  jitter;

  modport source (output valid, output cmd, output jitter, input ready);
  modport sink   (input valid, input cmd, input jitter, output ready);
endinterface

interface ssfs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        draw;
  logic [ssfs_pkg::VAL_W-1:0]  source_x;
  logic [ssfs_pkg::VAL_W-1:0]  source_y;
  logic                        active;

  modport source (output valid, output draw, output source_x, output source_y,
                  output active, input ready);
  modport sink   (input valid, input draw, input source_x, input source_y,
                  input active, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ssfs_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned; nbits sets how many bits are consumed.
module ssfs_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [ssfs_pkg::DVD_W-1:0]        dividend,
  input  wire logic [ssfs_pkg::DVS_W-1:0]        divisor,
  input  wire logic [ssfs_pkg::DIV_CNT_W-1:0]    nbits,
  output logic                                   done,
  output logic [ssfs_pkg::DVS_W-1:0]             quotient,
  output logic [ssfs_pkg::DVS_W-1:0]             remainder
);

  logic [ssfs_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [ssfs_pkg::DVS_W-1:0]     dvs_r;
  logic [ssfs_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [ssfs_pkg::DVS_W-1:0]     quo_r, quo_nxt;
  logic [ssfs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [ssfs_pkg::DVS_W:0]       trial;
  logic [ssfs_pkg::DVS_W:0]       diff;

  // one shift-and-subtract step
  always_comb begin
    trial    = {rem_r, dvd_r[ssfs_pkg::DVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = nbits;
    end else if (cnt_r != '0) begin
      dvd_nxt = {dvd_r[ssfs_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[ssfs_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[ssfs_pkg::DVS_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ssfs_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[ssfs_pkg::DVS_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == ssfs_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ssfs_dp.sv
`default_nettype none
module ssfs_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [ssfs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ssfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [ssfs_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [ssfs_pkg::JIT_W-1:0]         in_jitter,
  input  wire ssfs_pkg::ctrl_cmd_t                cmd,
  output ssfs_pkg::dp_status_t                    status,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic                                    out_draw,
  output logic [ssfs_pkg::VAL_W-1:0]              out_source_x,
  output logic [ssfs_pkg::VAL_W-1:0]              out_source_y,
  output logic                                    out_active
);

  localparam int VW = ssfs_pkg::VAL_W;
  localparam int WW = ssfs_pkg::WAIT_W;
  localparam int RW = ssfs_pkg::REP_W;

  typedef enum logic [1:0] {SEL_FPR, SEL_MOD, SEL_Y} div_sel_t;

  // configuration
  logic [VW-1:0] frame_count_r, frame_width_r, frame_height_r, frame_gap_r;
  logic [VW-1:0] sheet_width_r, frame_rate_r, repeat_limit_r;
  logic          loop_mode_r;

  // sequencer state
  logic          running_r, suspended_r, stepping_down_r;
  logic [WW-1:0] wait_count_r;
  logic [VW-1:0] frame_index_r;
  logic [RW-1:0] repeats_done_r;
  logic [VW-1:0] frames_per_row_r;

  // transaction and work registers
  logic [ssfs_pkg::CMD_W-1:0] cmd_r;
  logic [ssfs_pkg::JIT_W-1:0] jit_r;
  logic                       draw_r, step_r;
  logic [ssfs_pkg::DVD_W-1:0] prod_r;
  logic [VW-1:0]              sx_r, sy_r, yq_r;
  div_sel_t                   div_sel_r;

  // output register
  logic          out_valid_r, out_draw_r, out_active_r;
  logic [VW-1:0] out_sx_r, out_sy_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= VW'(1);
      frame_width_r  <= VW'(1);
      frame_height_r <= VW'(1);
      frame_gap_r    <= '0;
      sheet_width_r  <= VW'(1);
      frame_rate_r   <= VW'(1);
      repeat_limit_r <= '0;
      loop_mode_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ssfs_pkg::REG_FRAME_COUNT:  frame_count_r  <= cfg_wdata;
        ssfs_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        ssfs_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        ssfs_pkg::REG_FRAME_GAP:    frame_gap_r    <= cfg_wdata;
        ssfs_pkg::REG_SHEET_WIDTH:  sheet_width_r  <= cfg_wdata;
        ssfs_pkg::REG_FRAME_RATE:   frame_rate_r   <= cfg_wdata;
        ssfs_pkg::REG_REPEAT_LIMIT: repeat_limit_r <= cfg_wdata;
        ssfs_pkg::REG_LOOP_MODE:    loop_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // tick evaluation on the current state
  logic [WW-1:0] wait_dec, reload, reload_fix;
  logic [RW-1:0] rep_a, rep_b;
  logic [VW-1:0] last_index, index_eval;
  logic          at_first, at_last, tick_ok, expire, dir_eval, draw_eval;
  logic [RW-1:0] limit_ext;

  always_comb begin
    limit_ext  = {1'b0, repeat_limit_r};
    tick_ok    = (cmd_r == ssfs_pkg::CMD_TICK) && !suspended_r && running_r &&
                 (repeats_done_r <= limit_ext);
    wait_dec   = wait_count_r - 1'b1;
    expire     = tick_ok && (wait_dec == '0);
    reload     = {1'b0, frame_rate_r} + WW'(jit_r);
    reload_fix = (reload == '0) ? WW'(1) : reload;
    last_index = frame_count_r - 1'b1;
    at_first   = (frame_index_r == '0);
    at_last    = (frame_index_r == last_index);
    rep_a      = repeats_done_r;
    dir_eval   = stepping_down_r;
    index_eval = frame_index_r;
    if (at_first) begin
      rep_a    = (repeats_done_r == '1) ? repeats_done_r : repeats_done_r + 1'b1;
      dir_eval = 1'b0;
    end
    rep_b = rep_a;
    if (at_last) begin
      rep_b = (rep_a == '1) ? rep_a : rep_a + 1'b1;
      if (loop_mode_r) begin
        index_eval = '0;
      end else begin
        dir_eval = 1'b1;
      end
    end
    draw_eval = expire && (rep_b <= limit_ext);
  end

  // shared divider operand selection
  logic                           div_start;
  logic [ssfs_pkg::DVD_W-1:0]     div_dvd;
  logic [ssfs_pkg::DVS_W-1:0]     div_dvs;
  logic [ssfs_pkg::DIV_CNT_W-1:0] div_n;
  logic                           div_done;
  logic [ssfs_pkg::DVS_W-1:0]     div_quo, div_rem;
  logic [ssfs_pkg::DVS_W-1:0]     row_num, row_den;

  always_comb begin
    row_num   = {1'b0, sheet_width_r} + {1'b0, frame_gap_r};
    row_den   = {1'b0, frame_width_r} + {1'b0, frame_gap_r};
    div_start = cmd.div_fpr || cmd.div_mod || cmd.div_y;
    priority if (cmd.div_fpr) begin
      div_dvd = {row_num, {(ssfs_pkg::DVD_W-ssfs_pkg::DVS_W){1'b0}}};
      div_dvs = row_den;
      div_n   = ssfs_pkg::DIV_CNT_W'(ssfs_pkg::DVS_W);
    end else if (cmd.div_mod) begin
      div_dvd = prod_r;
      div_dvs = {1'b0, sheet_width_r};
      div_n   = ssfs_pkg::DIV_CNT_W'(ssfs_pkg::DVD_W);
    end else begin
      div_dvd = {frame_index_r, {(ssfs_pkg::DVD_W-VW){1'b0}}};
      div_dvs = {1'b0, frames_per_row_r};
      div_n   = ssfs_pkg::DIV_CNT_W'(VW);
    end
  end

  ssfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .nbits     (div_n),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // row height and products
  logic [VW-1:0]              row_height;
  logic [ssfs_pkg::DVD_W-1:0] prod_nxt;
  logic [2*VW-1:0]            y_prod;

  always_comb begin
    row_height = frame_height_r + VW'(ssfs_pkg::ROW_GAP);
    prod_nxt   = {{(ssfs_pkg::DVD_W-ssfs_pkg::DVS_W){1'b0}}, row_den} *
                 {{(ssfs_pkg::DVD_W-VW){1'b0}}, frame_index_r};
    y_prod     = yq_r * row_height;
  end

  // sequencer state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r        <= 1'b0;
      suspended_r      <= 1'b0;
      stepping_down_r  <= 1'b0;
      wait_count_r     <= '0;
      frame_index_r    <= '0;
      repeats_done_r   <= '0;
      frames_per_row_r <= '0;
    end else begin
      if (cmd.exec) begin
        unique case (cmd_r)
          ssfs_pkg::CMD_TICK: begin
            if (tick_ok) begin
              wait_count_r <= expire ? reload_fix : wait_dec;
            end
            if (expire) begin
              repeats_done_r  <= rep_b;
              stepping_down_r <= dir_eval;
              frame_index_r   <= index_eval;
            end
          end
          ssfs_pkg::CMD_START: begin
            frame_index_r   <= '0;
            stepping_down_r <= 1'b0;
            repeats_done_r  <= '0;
            wait_count_r    <= WW'(1);
            running_r       <= 1'b1;
            suspended_r     <= 1'b0;
          end
          ssfs_pkg::CMD_STOP:    running_r   <= 1'b0;
          ssfs_pkg::CMD_SUSPEND: suspended_r <= 1'b1;
          ssfs_pkg::CMD_RESUME:  suspended_r <= 1'b0;
          default: ;
        endcase
      end
      // frames per row, saturated, zero for a zero divisor
      if (div_done && (div_sel_r == SEL_FPR)) begin
        if (row_den == '0) begin
          frames_per_row_r <= '0;
        end else if (div_quo[ssfs_pkg::DVS_W-1]) begin
          frames_per_row_r <= '1;
        end else begin
          frames_per_row_r <= div_quo[VW-1:0];
        end
      end
      // index moves one step once the frame is out
      if (cmd.fin && step_r) begin
        frame_index_r <= stepping_down_r ? frame_index_r - 1'b1 : frame_index_r + 1'b1;
      end
    end
  end

  // transaction capture and coordinate work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      jit_r <= in_jitter;
    end
    if (cmd.exec) begin
      draw_r <= draw_eval;
      step_r <= expire;
    end
    if (div_start) begin
      priority if (cmd.div_fpr) begin
        div_sel_r <= SEL_FPR;
      end else if (cmd.div_mod) begin
        div_sel_r <= SEL_MOD;
      end else begin
        div_sel_r <= SEL_Y;
      end
    end
    if (cmd.mul_x) begin
      prod_r <= prod_nxt;
    end
    if (div_done && (div_sel_r == SEL_MOD)) begin
      sx_r <= (sheet_width_r == '0) ? prod_r[VW-1:0] : div_rem[VW-1:0];
    end
    if (div_done && (div_sel_r == SEL_Y)) begin
      yq_r <= (frames_per_row_r == '0) ? '0 : div_quo[VW-1:0];
    end
    if (cmd.mul_y) begin
      sy_r <= y_prod[VW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_draw_r   <= draw_r;
      out_sx_r     <= draw_r ? sx_r : '0;
      out_sy_r     <= draw_r ? sy_r : '0;
      out_active_r <= running_r;
    end
  end

  assign status.is_start = (cmd_r == ssfs_pkg::CMD_START);
  assign status.draw_go  = draw_eval;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_draw     = out_draw_r;
  assign out_source_x = out_sx_r;
  assign out_source_y = out_sy_r;
  assign out_active   = out_active_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ssfs_ctrl.sv
`default_nettype none
module ssfs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ssfs_pkg::dp_status_t  status,
  output ssfs_pkg::ctrl_cmd_t        cmd
);

  ssfs_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssfs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of one command
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ssfs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ssfs_pkg::S_EXEC;
        end
      end
      ssfs_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (status.is_start) begin
          cmd.div_fpr = 1'b1;
          state_nxt   = ssfs_pkg::S_DIVF;
        end else if (status.draw_go) begin
          state_nxt = ssfs_pkg::S_MULX;
        end else begin
          state_nxt = ssfs_pkg::S_FIN;
        end
      end
      ssfs_pkg::S_DIVF: begin
        if (status.div_done) begin
          state_nxt = ssfs_pkg::S_FIN;
        end
      end
      ssfs_pkg::S_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = ssfs_pkg::S_MODS;
      end
      ssfs_pkg::S_MODS: begin
        cmd.div_mod = 1'b1;
        state_nxt   = ssfs_pkg::S_MODW;
      end
      ssfs_pkg::S_MODW: begin
        if (status.div_done) begin
          state_nxt = ssfs_pkg::S_YS;
        end
      end
      ssfs_pkg::S_YS: begin
        cmd.div_y = 1'b1;
        state_nxt = ssfs_pkg::S_YW;
      end
      ssfs_pkg::S_YW: begin
        if (status.div_done) begin
          state_nxt = ssfs_pkg::S_MULY;
        end
      end
      ssfs_pkg::S_MULY: begin
        cmd.mul_y = 1'b1;
        state_nxt = ssfs_pkg::S_FIN;
      end
      ssfs_pkg::S_FIN: begin
        if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ssfs_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssfs_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sprite_sheet_frame_sequencer_top.sv
`default_nettype none
// Sprite sheet frame sequencer. Each input transaction is one command (tick,
// start, stop, suspend, resume) and yields exactly one result transaction
// carrying draw, the sheet coordinates of the frame and the active flag.
// Commands are handled one at a time. Stop, suspend, resume, unused codes and
// ticks that draw nothing go straight from execution to the result; start
// waits on the 17-step frames-per-row division; a tick that draws waits on
// the shared one-bit-per-cycle divider running the 33-step source x modulo
// and then the 16-step row division. A finished result sits in the output
// register, so the next command is accepted while it waits. Write
// configuration only while idle.
module sprite_sheet_frame_sequencer_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ssfs_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ssfs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ssfs_in_if.sink                               in_ch,
  ssfs_out_if.source                            out_ch
);

  ssfs_pkg::ctrl_cmd_t  cmd;
  ssfs_pkg::dp_status_t status;

  ssfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssfs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_cmd       (in_ch.cmd),
    .in_jitter    (in_ch.jitter),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_draw     (out_ch.draw),
    .out_source_x (out_ch.source_x),
    .out_source_y (out_ch.source_y),
    .out_active   (out_ch.active)
  );

`ifndef SYNTHESIS
  // one command in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a command is in flight");

  // a drawn frame belongs to a running animation
  a_draw_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.draw) |-> out_ch.active)
    else $error("draw reported while not active");

  // a new result is loaded only while the input side is closed
  a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result loaded while idle");
`endif

endmodule
`default_nettype wire
